// ===== src/xles_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xles_pkg: shared types and constants of the XMI loop event scanner
// Holds the request and result records, the queue entry and the parser codes.
// ---------------------------------------------------------------------------
package xles_pkg;

	// Input request and result record, as seen on the ports.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        record_kind;
		logic [31:0] event_index;
		logic [31:0] tick_time;
		logic [31:0] byte_offset;
		logic [3:0]  channel;
		logic        is_loop_next;
		logic [7:0]  ctrl_value;
		logic [7:0]  nest_depth;
		logic [7:0]  events_found;
		logic        parse_stopped;
		logic        last_of_run;
	} out_item_t;

	localparam logic KIND_LOOP    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Byte classes decided by the front end.
	typedef enum logic [2:0] {
		CLS_DELTA,
		CLS_META,
		CLS_SYSEX,
		CLS_SKIP2,
		CLS_SKIP1,
		CLS_NOTE,
		CLS_CC,
		CLS_UNKNOWN
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		cls_t       cls;
	} q_entry_t;

	// Head of the request queue as offered to the back end.
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} fq_head_t;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_DELTA,
		PH_METATYPE,
		PH_LENVLQ,
		PH_SKIP,
		PH_NOTEDATA,
		PH_DURVLQ,
		PH_CCNUM,
		PH_CCVAL
	} phase_t;

	typedef enum logic [1:0] {
		HALT_RUN,
		HALT_UNKNOWN,
		HALT_LIMIT
	} halt_t;

	// Status bytes and status nibbles.
	localparam logic [7:0] DELTA_LIMIT   = 8'h80;
	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
	localparam logic [3:0] NIB_AFTERTCH  = 4'hA;
	localparam logic [3:0] NIB_CTRL      = 4'hB;
	localparam logic [3:0] NIB_PROGRAM   = 4'hC;
	localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
	localparam logic [3:0] NIB_PITCH     = 4'hE;

	localparam logic [7:0] CTL_LOOP_START = 8'd116;
	localparam logic [7:0] CTL_LOOP_NEXT  = 8'd117;
	localparam logic [7:0] DEPTH_MAX      = 8'hFF;

	// Queue sizes.
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_EVENTS = '0;
	localparam logic [7:0] MAX_EVENTS_RESET = 8'd10;

endpackage
`default_nettype wire

// ===== src/xles_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xles_front: request intake and byte classification
// Classifies each accepted byte and holds it in a short queue for the parser.
// ---------------------------------------------------------------------------
module xles_front
	import xles_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_ready,
	input  wire in_item_t byte_data,
	output fq_head_t      head,
	input  wire logic     pop
);

	q_entry_t              mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0]   wr_ptr_q;
	logic [FQ_PTR_W-1:0]   rd_ptr_q;
	logic [FQ_CNT_W-1:0]   count_q;
	logic                  push;
	cls_t                  cls;
	q_entry_t              new_entry;

	// The class only matters for a byte seen in the delta phase.
	always_comb begin
		if (byte_data.data_byte < DELTA_LIMIT) begin
			cls = CLS_DELTA;
		end else if (byte_data.data_byte == ST_META) begin
			cls = CLS_META;
		end else if (byte_data.data_byte inside {ST_SYSEX, ST_SYSEX_ESC}) begin
			cls = CLS_SYSEX;
		end else begin
			case (byte_data.data_byte[7:4])
				NIB_NOTE_OFF, NIB_AFTERTCH, NIB_PITCH: cls = CLS_SKIP2;
				NIB_PROGRAM, NIB_CHAN_PRES:            cls = CLS_SKIP1;
				NIB_NOTE_ON:                           cls = CLS_NOTE;
				NIB_CTRL:                              cls = CLS_CC;
				default:                               cls = CLS_UNKNOWN;
			endcase
		end
	end

	assign new_entry.data_byte = byte_data.data_byte;
	assign new_entry.last_byte = byte_data.last_byte;
	assign new_entry.cls       = cls;

	assign byte_ready = (count_q != FQ_CNT_W'(FQ_DEPTH));
	assign push       = byte_valid && byte_ready;

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FQ_PTR_W'(1);
			end
			count_q <= count_q + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/xles_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xles_back: event parser and result queue
// Runs one classified byte per cycle through the parser while the result queue has room, and queues results.
// ---------------------------------------------------------------------------
module xles_back
	import xles_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire fq_head_t   head,
	output logic            pop,
	input  wire logic [7:0] max_events,
	output logic            rec_valid,
	input  wire logic       rec_ready,
	output out_item_t       rec_data
);

	// Parser state.
	phase_t       phase_q, phase_n;
	halt_t        halt_q, halt_n;
	logic [31:0]  tick_q, tick_n;
	logic [31:0]  evt_q, evt_n;
	logic [31:0]  pos_q, pos_n;
	logic [31:0]  status_q, status_n;
	logic [3:0]   chan_q, chan_n;
	logic [7:0]   ctl_q, ctl_n;
	logic [31:0]  skip_q, skip_n;
	logic [31:0]  len_q, len_n;
	logic [7:0]   loop_q, loop_n;
	logic [7:0]   found_q, found_n;

	logic [7:0]   b;
	logic         last;
	logic [31:0]  len_shift;
	logic [31:0]  skip_dec;
	logic         rec_fire;
	logic         rec_next;
	logic [7:0]   rec_depth;
	logic         done;

	out_item_t             rec_item;
	out_item_t             sum_item;
	out_item_t             rq_mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   rq_wr_q;
	logic [RQ_PTR_W-1:0]   rq_rd_q;
	logic [RQ_CNT_W-1:0]   rq_count_q;
	logic [RQ_CNT_W-1:0]   rq_free;
	logic [RQ_CNT_W-1:0]   need;
	logic                  rq_take;

	assign b         = head.entry.data_byte;
	assign last      = head.entry.last_byte;
	assign len_shift = {len_q[24:0], b[6:0]};
	assign skip_dec  = skip_q - 32'd1;

	always_comb begin
		phase_n   = phase_q;
		halt_n    = halt_q;
		tick_n    = tick_q;
		status_n  = status_q;
		chan_n    = chan_q;
		ctl_n     = ctl_q;
		skip_n    = skip_q;
		len_n     = len_q;
		loop_n    = loop_q;
		found_n   = found_q;
		rec_fire  = 1'b0;
		rec_next  = 1'b0;
		rec_depth = loop_q;
		done      = 1'b0;
		if (halt_q == HALT_RUN) begin
			case (phase_q)
				PH_DELTA: begin
					if (found_q >= max_events) begin
						halt_n = HALT_LIMIT;
					end else if (head.entry.cls == CLS_DELTA) begin
						tick_n = tick_q + {24'd0, b};
					end else begin
						status_n = pos_q;
						chan_n   = b[3:0];
						case (head.entry.cls)
							CLS_META: phase_n = PH_METATYPE;
							CLS_SYSEX: begin
								len_n   = '0;
								phase_n = PH_LENVLQ;
							end
							CLS_SKIP2: begin
								skip_n  = 32'd2;
								phase_n = PH_SKIP;
							end
							CLS_SKIP1: begin
								skip_n  = 32'd1;
								phase_n = PH_SKIP;
							end
							CLS_NOTE: begin
								skip_n  = 32'd2;
								phase_n = PH_NOTEDATA;
							end
							CLS_CC:  phase_n = PH_CCNUM;
							default: halt_n  = HALT_UNKNOWN;
						endcase
					end
				end
				PH_METATYPE: begin
					len_n   = '0;
					phase_n = PH_LENVLQ;
				end
				PH_LENVLQ: begin
					len_n = len_shift;
					if (!b[7]) begin
						if (len_shift == '0) begin
							done = 1'b1;
						end else begin
							skip_n  = len_shift;
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						done = 1'b1;
					end
				end
				PH_NOTEDATA: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						phase_n = PH_DURVLQ;
					end
				end
				PH_DURVLQ: begin
					if (!b[7]) begin
						done = 1'b1;
					end
				end
				PH_CCNUM: begin
					ctl_n   = b;
					phase_n = PH_CCVAL;
				end
				PH_CCVAL: begin
					if ((ctl_q == CTL_LOOP_START || ctl_q == CTL_LOOP_NEXT) &&
						found_q < max_events) begin
						rec_fire = 1'b1;
						rec_next = (ctl_q == CTL_LOOP_NEXT);
						if (!rec_next) begin
							if (loop_q != DEPTH_MAX) begin
								loop_n = loop_q + 8'd1;
							end
							rec_depth = loop_n;
						end else begin
							rec_depth = loop_q;
							if (loop_q != '0) begin
								loop_n = loop_q - 8'd1;
							end
						end
						found_n = found_q + 8'd1;
					end
					done = 1'b1;
				end
				default: phase_n = PH_DELTA;
			endcase
		end
		if (done) begin
			phase_n = PH_DELTA;
		end
	end

	assign evt_n = done ? evt_q + 32'd1 : evt_q;
	assign pos_n = pos_q + 32'd1;

	always_comb begin
		rec_item.record_kind   = KIND_LOOP;
		rec_item.event_index   = evt_q;
		rec_item.tick_time     = tick_q;
		rec_item.byte_offset   = status_q;
		rec_item.channel       = chan_q;
		rec_item.is_loop_next  = rec_next;
		rec_item.ctrl_value    = b;
		rec_item.nest_depth    = rec_depth;
		rec_item.events_found  = found_n;
		rec_item.parse_stopped = (halt_n == HALT_UNKNOWN);
		rec_item.last_of_run   = !last;

		sum_item.record_kind   = KIND_SUMMARY;
		sum_item.event_index   = evt_n;
		sum_item.tick_time     = tick_n;
		sum_item.byte_offset   = pos_n;
		sum_item.channel       = '0;
		sum_item.is_loop_next  = 1'b0;
		sum_item.ctrl_value    = '0;
		sum_item.nest_depth    = loop_n;
		sum_item.events_found  = found_n;
		sum_item.parse_stopped = (halt_n == HALT_UNKNOWN);
		sum_item.last_of_run   = 1'b1;
	end

	// A byte moves on only when the result queue has room for all it makes.
	assign need    = RQ_CNT_W'(rec_fire) + RQ_CNT_W'(last);
	assign rq_free = RQ_CNT_W'(RQ_DEPTH) - rq_count_q;
	assign pop     = head.valid && (rq_free >= need);

	assign rec_valid = (rq_count_q != '0);
	assign rec_data  = rq_mem_q[rq_rd_q];
	assign rq_take   = rec_valid && rec_ready;

	always_ff @(posedge clk) begin
		if (pop && (rec_fire || last)) begin
			rq_mem_q[rq_wr_q] <= rec_fire ? rec_item : sum_item;
		end
		if (pop && rec_fire && last) begin
			rq_mem_q[rq_wr_q + RQ_PTR_W'(1)] <= sum_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q    <= '0;
			rq_rd_q    <= '0;
			rq_count_q <= '0;
		end else begin
			if (pop) begin
				rq_wr_q <= rq_wr_q + need[RQ_PTR_W-1:0];
			end
			if (rq_take) begin
				rq_rd_q <= rq_rd_q + RQ_PTR_W'(1);
			end
			rq_count_q <= rq_count_q + (pop ? need : '0) - RQ_CNT_W'(rq_take);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			halt_q   <= HALT_RUN;
			tick_q   <= '0;
			evt_q    <= '0;
			pos_q    <= '0;
			status_q <= '0;
			chan_q   <= '0;
			ctl_q    <= '0;
			skip_q   <= '0;
			len_q    <= '0;
			loop_q   <= '0;
			found_q  <= '0;
		end else if (pop) begin
			if (last) begin
				phase_q  <= PH_DELTA;
				halt_q   <= HALT_RUN;
				tick_q   <= '0;
				evt_q    <= '0;
				pos_q    <= '0;
				status_q <= '0;
				chan_q   <= '0;
				ctl_q    <= '0;
				skip_q   <= '0;
				len_q    <= '0;
				loop_q   <= '0;
				found_q  <= '0;
			end else begin
				phase_q  <= phase_n;
				halt_q   <= halt_n;
				tick_q   <= tick_n;
				evt_q    <= evt_n;
				pos_q    <= pos_n;
				status_q <= status_n;
				chan_q   <= chan_n;
				ctl_q    <= ctl_n;
				skip_q   <= skip_n;
				len_q    <= len_n;
				loop_q   <= loop_n;
				found_q  <= found_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/xmi_loop_event_scanner_core.sv =====
`default_nettype none
// Throughput: one byte per cycle while the result queue has room for the byte's results.
// A byte leaves the four-entry request queue only when the four-entry result queue
// has room for all its results (two when a loop record falls on the final byte).
// Reset (arst_n low, asynchronous) empties both queues, clears all parser state and
// sets max_events to 10.
// ---------------------------------------------------------------------------
// xmi_loop_event_scanner_core: XMI event chunk loop scanner
// Parses an XMI event stream byte by byte, reports loop controllers and a
// summary at the end of each chunk.
// ---------------------------------------------------------------------------
module xmi_loop_event_scanner_core
	import xles_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Byte requests.
	input  wire logic                  byte_valid,
	output logic                       byte_ready,
	input  wire in_item_t              byte_data,
	// Result records.
	output logic                       rec_valid,
	input  wire logic                  rec_ready,
	output out_item_t                  rec_data,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	// The only register is the record limit at byte address zero. Writes
	// land on the access cycle; the low two address bits are ignored.
	logic [7:0]           max_events_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_MAX_EVENTS);
	assign prdata  = (reg_idx == REG_MAX_EVENTS) ? {24'd0, max_events_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_events_q <= MAX_EVENTS_RESET;
		end else if (reg_wr) begin
			max_events_q <= pwdata[7:0];
		end
	end

	// The front end takes every byte the request queue has room for and tags
	// it with its status class, so the parser never waits on decoding.
	fq_head_t head;
	logic     pop;

	xles_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.head       (head),
		.pop        (pop)
	);

	// The back end advances the parser by one byte per cycle while its result
	// queue has room, writing loop records and the end-of-chunk summary there;
	// while the consumer stalls it accepts only bytes that make no results.
	xles_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.max_events (max_events_q),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec_data   (rec_data)
	);

	// A summary always closes the run of results for its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == KIND_SUMMARY |-> rec_data.last_of_run)
	else $error("summary record without last_of_run");

	// Loop records are only produced while parsing is still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == KIND_LOOP |-> !rec_data.parse_stopped)
	else $error("loop record after parsing halted");

	// A loop record counts itself and never passes the configured limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == KIND_LOOP |->
			rec_data.events_found != 8'd0 && rec_data.events_found <= max_events_q)
	else $error("loop record count outside the configured limit");

endmodule
`default_nettype wire
